// ===== hdl/plist_pkg.sv =====
// Shared constants for the positional list engine: field widths, operation and status codes.
package plist_pkg;

  // Fixed field widths of one item and one result.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned STAT_W  = 2;

  // Operation codes carried by func.
  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_POS  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_HEAD = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_TAIL = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_POS  = 3'd5;
  localparam logic [FUNC_W-1:0] FN_LIST     = 3'd6;

  // Status codes returned with each result.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Position that stands for "past the end" and is clamped to the list.
  localparam logic [POS_W-1:0] POS_END = {POS_W{1'b1}};

endpackage

// ===== hdl/plist_mem.sv =====
// Entry store of the list: one write port and one registered read port.
module plist_mem
  import plist_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/positional_list_engine.sv =====
// Top level of the positional list engine: operation sequencer, entry store and result register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in a
// single-port-write, single-port-read memory and works on one item at a time;
// in_stall is high from the cycle after acceptance until the item's last result
// has been loaded into the output register. Every entry move goes through the
// one memory read and write port, one entry per cycle, so an insert or delete
// takes longer the more entries lie behind its position, and a full or empty
// refusal returns only its status. A list emits one result per cycle while
// out_stall is low. Func code 7 is accepted and ignored. The output register
// lets the next item be accepted while the previous result still waits to be
// taken.
module positional_list_engine
  import plist_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [FUNC_W-1:0]                    func,
  input  logic signed [VALUE_W-1:0]            value,
  input  logic [POS_W-1:0]                     position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [VALUE_W-1:0]            item_value,
  output logic [STAT_W-1:0]                    status,
  output logic [$clog2(CAPACITY+1)-1:0]        length,
  output logic                                 last
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned LEN_W = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DRD  = 8'b0000_0010,
    S_DCAP = 8'b0000_0100,
    S_MOVE = 8'b0000_1000,
    S_PUT  = 8'b0001_0000,
    S_EMIT = 8'b0010_0000,
    S_LRD  = 8'b0100_0000,
    S_LOUT = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [LEN_W-1:0]    count, count_next;
  logic [AW-1:0]       slot, slot_next;
  logic [AW-1:0]       src, src_next;
  logic [AW-1:0]       dst, dst_next;
  logic [LEN_W-1:0]    moves, moves_next;
  logic                dir_up, dir_up_next;
  logic                pend, pend_next;
  logic [AW-1:0]       idx, idx_next;
  logic [VALUE_W-1:0]  ins_val, ins_val_next;
  logic [VALUE_W-1:0]  res_val, res_val_next;
  logic [STAT_W-1:0]   res_stat, res_stat_next;

  // Memory port controls.
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [VALUE_W-1:0]  wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [VALUE_W-1:0]  rd_data;

  // Result register load.
  logic                out_free;
  logic                load;
  logic [VALUE_W-1:0]  load_val;
  logic [STAT_W-1:0]   load_stat;
  logic                load_last;

  // Position clamping helpers.
  logic [POS_W-1:0]    cnt8;
  logic [POS_W-1:0]    last8;
  logic [POS_W-1:0]    pos_e;
  logic [POS_W-1:0]    ins_c8;
  logic [POS_W-1:0]    del_c8;
  logic                list_last;

  plist_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Effective position of the requested operation, clamped to the list.
  always_comb begin
    cnt8  = POS_W'(count);
    last8 = cnt8 - POS_W'(1);
    unique case (func) inside
      FN_INS_HEAD, FN_DEL_HEAD: pos_e = '0;
      FN_INS_TAIL, FN_DEL_TAIL: pos_e = POS_END;
      default:                  pos_e = position;
    endcase
    ins_c8 = (pos_e > cnt8) ? cnt8 : pos_e;
    del_c8 = (pos_e > last8) ? last8 : pos_e;
  end

  assign list_last = (LEN_W'(idx) == (count - LEN_W'(1)));

  // Operation sequencer.
  always_comb begin
    state_next    = state;
    count_next    = count;
    slot_next     = slot;
    src_next      = src;
    dst_next      = dst;
    moves_next    = moves;
    dir_up_next   = dir_up;
    pend_next     = pend;
    idx_next      = idx;
    ins_val_next  = ins_val;
    res_val_next  = res_val;
    res_stat_next = res_stat;
    wr_en         = 1'b0;
    wr_addr       = slot;
    wr_data       = ins_val;
    rd_en         = 1'b0;
    rd_addr       = slot;
    load          = 1'b0;
    load_val      = res_val;
    load_stat     = res_stat;
    load_last     = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_val_next  = '0;
          res_stat_next = ST_OK;
          pend_next     = 1'b0;
          unique case (func) inside
            FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
              if (count == LEN_W'(CAPACITY)) begin
                res_stat_next = ST_FULL;
                state_next    = S_EMIT;
              end else begin
                slot_next    = AW'(ins_c8);
                moves_next   = LEN_W'(cnt8 - ins_c8);
                src_next     = AW'(last8);
                dir_up_next  = 1'b1;
                ins_val_next = value;
                state_next   = S_MOVE;
              end
            end
            FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
              if (count == '0) begin
                res_stat_next = ST_EMPTY;
                state_next    = S_EMIT;
              end else begin
                slot_next   = AW'(del_c8);
                moves_next  = LEN_W'(last8 - del_c8);
                src_next    = AW'(del_c8 + POS_W'(1));
                dir_up_next = 1'b0;
                state_next  = S_DRD;
              end
            end
            FN_LIST: begin
              if (count == '0) begin
                res_stat_next = ST_EMPTY;
                state_next    = S_EMIT;
              end else begin
                idx_next   = '0;
                state_next = S_LRD;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      // Fetch the entry that a delete removes.
      S_DRD: begin
        rd_en      = 1'b1;
        rd_addr    = slot;
        state_next = S_DCAP;
      end

      S_DCAP: begin
        res_val_next = rd_data;
        state_next   = S_MOVE;
      end

      // Move entries by one place: read one entry while writing the previous one.
      S_MOVE: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = dst;
          wr_data = rd_data;
        end
        if (moves != '0) begin
          rd_en      = 1'b1;
          rd_addr    = src;
          dst_next   = dir_up ? (src + AW'(1)) : (src - AW'(1));
          src_next   = dir_up ? (src - AW'(1)) : (src + AW'(1));
          moves_next = moves - LEN_W'(1);
          pend_next  = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (dir_up) begin
              state_next = S_PUT;
            end else begin
              count_next = count - LEN_W'(1);
              state_next = S_EMIT;
            end
          end
        end
      end

      // Place the new value in the opened slot.
      S_PUT: begin
        wr_en      = 1'b1;
        wr_addr    = slot;
        wr_data    = ins_val;
        count_next = count + LEN_W'(1);
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_LRD: begin
        rd_en      = 1'b1;
        rd_addr    = idx;
        state_next = S_LOUT;
      end

      // Emit one entry per cycle while the result register is free, fetching the next one as this one is loaded.
      S_LOUT: begin
        if (out_free) begin
          load      = 1'b1;
          load_val  = rd_data;
          load_stat = ST_OK;
          load_last = list_last;
          if (list_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + AW'(1);
            rd_en    = 1'b1;
            rd_addr  = idx + AW'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    slot     <= slot_next;
    src      <= src_next;
    dst      <= dst_next;
    moves    <= moves_next;
    dir_up   <= dir_up_next;
    idx      <= idx_next;
    ins_val  <= ins_val_next;
    res_val  <= res_val_next;
    res_stat <= res_stat_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_value <= load_val;
      status     <= load_stat;
      length     <= count_next;
      last       <= load_last;
    end
  end

endmodule

// ===== dv/tb_positional_list_engine.sv =====
// Self-checking testbench for the positional list engine: random list operations under idling.
module tb_positional_list_engine import plist_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP          = 16;
  localparam int LEN_W        = $clog2(CAP + 1);
  localparam int PHASE_ITEMS  = 35;
  localparam int PRESS_ITEMS  = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 400000;
  localparam int REPORT_MAX   = 10;

  // The one func code that the block accepts and ignores.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } list_op_t;

  typedef struct {
    logic signed [VALUE_W-1:0] item_value;
    logic [STAT_W-1:0]         status;
    logic [LEN_W-1:0]          length;
    logic                      last;
  } list_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [FUNC_W-1:0]         func = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic [POS_W-1:0]          position = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] item_value;
  logic [STAT_W-1:0]         status;
  logic [LEN_W-1:0]          length;
  logic                      last;

  // Operations waiting to be offered and results the list should still produce.
  list_op_t     op_queue[$];
  list_result_t results_due[$];

  // Shadow copy of the list as the block should hold it.
  logic signed [VALUE_W-1:0] list_entries[CAP];
  int                        list_len = 0;

  // Length the stimulus generator expects, used to steer bursts toward full or empty.
  int gen_len = 0;

  idle_mode_t idle_mode = IDLE_NONE;
  logic       in_fire = 1'b0;
  int         hold_goal = 0;
  int         hold_done = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  logic [FUNC_W-1:0] ins_codes[3] = '{FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS};
  logic [FUNC_W-1:0] del_codes[3] = '{FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS};

  positional_list_engine #(.CAPACITY(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .value(value),
    .position(position),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .item_value(item_value),
    .status(status),
    .length(length),
    .last(last)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one operation to the shadow list and queue the results it causes.
  task automatic compute_list_op(input list_op_t op);
    int           p;
    int           i;
    list_result_t r;
    r.item_value = '0;
    r.status     = ST_OK;
    r.last       = 1'b1;
    case (op.func) inside
      FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
        if (list_len >= CAP) begin
          r.status = ST_FULL;
        end else begin
          if (op.func == FN_INS_HEAD) p = 0;
          else if (op.func == FN_INS_TAIL) p = list_len;
          else p = (int'(op.position) > list_len) ? list_len : int'(op.position);
          for (i = list_len; i > p; i--) list_entries[i] = list_entries[i-1];
          list_entries[p] = op.value;
          list_len++;
        end
        r.length = LEN_W'(list_len);
        results_due.push_back(r);
      end
      FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op.func == FN_DEL_HEAD) p = 0;
          else if (op.func == FN_DEL_TAIL) p = list_len - 1;
          else p = (int'(op.position) >= list_len) ? list_len - 1 : int'(op.position);
          r.item_value = list_entries[p];
          for (i = p; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
          list_len--;
        end
        r.length = LEN_W'(list_len);
        results_due.push_back(r);
      end
      FN_LIST: begin
        r.length = LEN_W'(list_len);
        if (list_len == 0) begin
          r.status = ST_EMPTY;
          results_due.push_back(r);
        end else begin
          for (i = 0; i < list_len; i++) begin
            r.item_value = list_entries[i];
            r.last       = (i + 1 == list_len);
            results_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Check each taken result against the oldest one due, then record accepted items.
  always @(posedge clk) begin : check_and_predict
    list_result_t want;
    list_op_t     op;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: value=%0d status=%0d length=%0d last=%0d",
                     item_value, status, length, last);
        end else begin
          want = results_due.pop_front();
          if (item_value !== want.item_value || status !== want.status ||
              length !== want.length || last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result mismatch: exp value=%0d status=%0d length=%0d last=%0d,",
                       want.item_value, want.status, want.length, want.last,
                       " got value=%0d status=%0d length=%0d last=%0d",
                       item_value, status, length, last);
          end
        end
      end
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        op.func     = func;
        op.value    = value;
        op.position = position;
        compute_list_op(op);
      end
    end
  end

  // Sender: offer the next item once the bus is free, idling at random per mode.
  always @(negedge clk) begin : sender
    int idle_pct;
    list_op_t op;
    idle_pct = (idle_mode == IDLE_SENDER) ? 65 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        op = op_queue.pop_front();
        func     <= op.func;
        value    <= op.value;
        position <= op.position;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when requested, otherwise random stalls per mode.
  always @(negedge clk) begin : receiver
    int stall_pct;
    stall_pct = (idle_mode == IDLE_RECEIVER) ? 65 : (idle_mode == IDLE_BOTH) ? 7 : 0;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_done < hold_goal) begin
      out_stall <= 1'b1;
      hold_done <= hold_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("positional_list_engine regression: fail");
      $finish;
    end
  end

  // Queue one item and track the length it should leave behind.
  task automatic push_op(input logic [FUNC_W-1:0] f, input logic signed [VALUE_W-1:0] v,
                         input logic [POS_W-1:0] p);
    list_op_t op;
    op.func     = f;
    op.value    = v;
    op.position = p;
    op_queue.push_back(op);
    if ((f == FN_INS_HEAD || f == FN_INS_TAIL || f == FN_INS_POS) && gen_len < CAP)
      gen_len++;
    else if ((f == FN_DEL_HEAD || f == FN_DEL_TAIL || f == FN_DEL_POS) && gen_len > 0)
      gen_len--;
  endtask

  // Random value, with the extremes and zero mixed in now and then.
  function automatic logic signed [VALUE_W-1:0] random_value();
    logic signed [VALUE_W-1:0] pick[4];
    pick = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1};
    if ($urandom_range(99) < 10) return pick[$urandom_range(3)];
    return $signed($urandom);
  endfunction

  // One random item; inserts win with the given percentage among inserts and deletes.
  task automatic add_random_op(input int ins_pct, inout int done);
    int                r;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;
    r = $urandom_range(99);
    if (r < 3) f = FN_UNUSED;
    else if (r < 13) f = FN_LIST;
    else if ($urandom_range(99) < ins_pct) f = ins_codes[$urandom_range(2)];
    else f = del_codes[$urandom_range(2)];
    // Mostly positions inside the list, sometimes anywhere in the field.
    if ($urandom_range(99) < 70) p = POS_W'($urandom_range(gen_len));
    else p = POS_W'($urandom_range(255));
    push_op(f, random_value(), p);
    if (f != FN_UNUSED) done++;
  endtask

  // Bursts that grow the list to full, shrink it to empty, or mix operations.
  task automatic run_random_phase(input int item_goal);
    int done;
    int kind;
    int n;
    done = 0;
    kind = 0;
    while (done < item_goal) begin
      case (kind)
        0: begin
          while (gen_len < CAP) add_random_op(85, done);
          n = $urandom_range(1, 3);
          repeat (n) begin
            push_op(ins_codes[$urandom_range(2)], random_value(), POS_W'($urandom_range(255)));
            done++;
          end
        end
        1: begin
          while (gen_len > 0) add_random_op(15, done);
          n = $urandom_range(1, 3);
          repeat (n) begin
            push_op(del_codes[$urandom_range(2)], random_value(), POS_W'($urandom_range(255)));
            done++;
          end
        end
        default: begin
          n = $urandom_range(8, 20);
          repeat (n) add_random_op(50, done);
        end
      endcase
      kind = $urandom_range(2);
    end
  endtask

  task automatic wait_offered();
    while (op_queue.size() != 0 || in_valid) @(posedge clk);
  endtask

  // Stimulus sequence and end of run.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: empty-list refusals, ignored code, extremes, clamped positions,
    // deleting the only entry, and listing empty and non-empty lists.
    push_op(FN_LIST, 32'sh0, 8'd0);
    push_op(FN_DEL_HEAD, 32'sh0, 8'd0);
    push_op(FN_DEL_TAIL, 32'sh0, 8'd0);
    push_op(FN_DEL_POS, 32'sh0, POS_END);
    push_op(FN_UNUSED, -32'sh1, POS_END);
    push_op(FN_INS_HEAD, 32'sh7FFF_FFFF, 8'd0);
    push_op(FN_INS_TAIL, 32'sh8000_0000, POS_END);
    push_op(FN_INS_POS, 32'sh0, 8'd1);
    push_op(FN_INS_POS, -32'sh1, POS_END);
    push_op(FN_LIST, 32'sh0, 8'd0);
    push_op(FN_DEL_POS, 32'sh0, 8'd1);
    push_op(FN_DEL_POS, 32'sh0, POS_END);
    push_op(FN_DEL_HEAD, 32'sh0, 8'd0);
    push_op(FN_DEL_TAIL, 32'sh0, 8'd0);
    push_op(FN_LIST, 32'sh0, 8'd0);
    push_op(FN_INS_POS, 32'sh5555_5555, 8'd0);
    push_op(FN_INS_POS, 32'shAAAA_AAAA, 8'd200);
    push_op(FN_INS_HEAD, 32'sh1234_5678, 8'd0);
    push_op(FN_LIST, 32'sh0, 8'd0);
    push_op(FN_DEL_POS, 32'sh0, 8'd0);
    wait_offered();

    // Random phases, one per idling mode.
    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_t'(m);
      run_random_phase(PHASE_ITEMS);
      wait_offered();
    end

    // Long receiver hold-off while items keep coming, so the input backs up.
    idle_mode = IDLE_NONE;
    hold_goal = hold_done + HOLD_CYCLES;
    run_random_phase(PRESS_ITEMS);
    wait_offered();

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("positional_list_engine regression: pass");
    else
      $display("positional_list_engine regression: fail");
    $finish;
  end

endmodule
